/* design/page_frame_allocator_refcount_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Shared property forms; every use samples on clock and is off in reset.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_DEFINES_SVH

// Check that an implication holds in the same cycle
`define PFA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that an implication holds in the next cycle
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/pfa_pkg.sv */
// ---------------------------------------------------------------------------
// Page frame allocator package
// Sizes, command and status codes, and the structs shared between the modules.
// ---------------------------------------------------------------------------
package pfa_pkg;

   localparam int NUM_FRAMES = 16384;
   localparam int COUNT_BITS = 8;
   localparam int FRAME_BITS = $clog2(NUM_FRAMES);
   localparam int DEPTH_BITS = $clog2(NUM_FRAMES + 1);
   localparam int CFG_BITS   = 15;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = DEPTH_BITS'(NUM_FRAMES);

   // Command codes of the request beat
   localparam logic [2:0] CMD_FREE  = 3'd0;
   localparam logic [2:0] CMD_ALLOC = 3'd1;
   localparam logic [2:0] CMD_INC   = 3'd2;
   localparam logic [2:0] CMD_DEC   = 3'd3;
   localparam logic [2:0] CMD_QUERY = 3'd4;
   localparam logic [2:0] CMD_SEED  = 3'd5;

   // Status codes of the response beat
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_WINDOW = 3'd1;
   localparam logic [2:0] ST_EMPTY  = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_SAT    = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_USABLE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_LIMIT  = 1'd1;

   typedef enum logic [2:0] {
      OP_FREE,
      OP_ALLOC,
      OP_INC,
      OP_DEC,
      OP_QUERY,
      OP_SEED,
      OP_WINDOW,
      OP_NOP
   } op_kind_type;

   typedef struct packed {
      logic [2:0]            command;
      logic [FRAME_BITS-1:0] frame_index;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [FRAME_BITS-1:0] given_frame;
      logic [COUNT_BITS-1:0] ref_count;
      logic [DEPTH_BITS-1:0] free_frames;
      logic                  was_pushed;
   } rsp_type;

   // Classified work item passed from front to back
   typedef struct packed {
      op_kind_type           kind;
      logic [FRAME_BITS-1:0] frame;
   } op_type;

   // Back-end status seen by the front
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

/* design/pfa_front.sv */
// ---------------------------------------------------------------------------
// Page frame allocator front end
// Holds the window registers, accepts request beats and classifies them.
// ---------------------------------------------------------------------------
module pfa_front
   import pfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   input  back_status_type           back_status,
   input  logic                      q_full,
   output logic                      q_push,
   output op_type                    q_op
);

   logic [CFG_BITS-1:0] first_usable_ff, first_usable_in;
   logic [CFG_BITS-1:0] frame_limit_ff,  frame_limit_in;
   logic                in_window;
   logic [CFG_BITS-1:0] frame_ext;

   // Update window registers on a write
   always_comb begin
      first_usable_in = first_usable_ff;
      frame_limit_in  = frame_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_USABLE: first_usable_in = csr_wdata;
            CSR_FRAME_LIMIT:  frame_limit_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_usable_ff <= '0;
         frame_limit_ff  <= CFG_BITS'(NUM_FRAMES);
      end else begin
         first_usable_ff <= first_usable_in;
         frame_limit_ff  <= frame_limit_in;
      end
   end

   // Hold requests while the queue is full or counts are still being cleared
   assign req_stall = q_full | back_status.clearing;
   assign q_push    = req_valid & ~req_stall;

   // Classify the beat against the window
   assign frame_ext = CFG_BITS'(req_data.frame_index);
   assign in_window = (frame_ext >= first_usable_ff) && (frame_ext < frame_limit_ff);

   always_comb begin
      q_op.frame = req_data.frame_index;
      case (req_data.command)
         CMD_ALLOC: q_op.kind = OP_ALLOC;
         CMD_FREE:  q_op.kind = in_window ? OP_FREE  : OP_WINDOW;
         CMD_INC:   q_op.kind = in_window ? OP_INC   : OP_WINDOW;
         CMD_DEC:   q_op.kind = in_window ? OP_DEC   : OP_WINDOW;
         CMD_QUERY: q_op.kind = in_window ? OP_QUERY : OP_WINDOW;
         CMD_SEED:  q_op.kind = in_window ? OP_SEED  : OP_WINDOW;
         default:   q_op.kind = OP_NOP;
      endcase
   end

endmodule

/* design/pfa_queue.sv */
// ---------------------------------------------------------------------------
// Page frame allocator work queue
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
module pfa_queue
   import pfa_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head_op,
   output logic   full,
   output logic   empty
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op = slot_ff[rd_ptr_ff];
   assign full    = fill_ff[1];
   assign empty   = (fill_ff == 2'd0);

endmodule

/* design/pfa_back.sv */
// ---------------------------------------------------------------------------
// Page frame allocator back end
// Owns count memory and free stack, runs each item as read then update.
// ---------------------------------------------------------------------------
`include "page_frame_allocator_refcount_defines.svh"

module pfa_back
   import pfa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  op_type          head_op,
   input  logic            q_empty,
   output logic            q_pop,
   output back_status_type back_status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [FRAME_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [DEPTH_BITS-1:0] stack_depth_ff, stack_depth_in;
   op_type                op_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS-1:0] count_mem_ff [NUM_FRAMES];
   logic [FRAME_BITS-1:0] stack_mem_ff [NUM_FRAMES];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [FRAME_BITS-1:0] stk_rd_ff;

   logic                  out_free;
   logic                  exec_go;
   logic                  cnt_we;
   logic [FRAME_BITS-1:0] cnt_wa;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic [COUNT_BITS-1:0] new_count;
   logic                  push_req;
   logic                  pop_req;
   logic [2:0]            status;
   logic [FRAME_BITS-1:0] given;
   logic [COUNT_BITS-1:0] ref_out;
   logic                  stack_full;
   logic [DEPTH_BITS-1:0] depth_less;

   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign exec_go     = (state_ff == S_EXEC) && out_free;
   assign q_pop       = (state_ff == S_IDLE) && !q_empty;
   assign stack_full  = (stack_depth_ff >= DEPTH_FULL);
   assign depth_less  = stack_depth_ff - 1'b1;
   assign back_status.clearing = (state_ff == S_CLEAR);

   // Work out the update from the fetched count or stack entry
   always_comb begin
      new_count = cnt_rd_ff;
      status    = ST_OK;
      given     = '0;
      ref_out   = '0;
      push_req  = 1'b0;
      pop_req   = 1'b0;
      cnt_we    = 1'b0;
      cnt_wa    = op_ff.frame;
      case (op_ff.kind)
         OP_FREE, OP_SEED: begin
            if (op_ff.kind == OP_SEED || cnt_rd_ff == '0) begin
               new_count = '0;
            end else begin
               new_count = cnt_rd_ff - 1'b1;
            end
            cnt_we  = 1'b1;
            ref_out = new_count;
            if (new_count == '0) begin
               if (stack_full) begin
                  status = ST_FULL;
               end else begin
                  push_req = 1'b1;
               end
            end
         end
         OP_INC: begin
            if (cnt_rd_ff == COUNT_MAX) begin
               status = ST_SAT;
            end else begin
               new_count = cnt_rd_ff + 1'b1;
            end
            cnt_we  = 1'b1;
            ref_out = new_count;
         end
         OP_DEC: begin
            if (cnt_rd_ff == '0) begin
               status = ST_SAT;
            end else begin
               new_count = cnt_rd_ff - 1'b1;
            end
            cnt_we  = 1'b1;
            ref_out = new_count;
         end
         OP_QUERY: begin
            ref_out = cnt_rd_ff;
         end
         OP_ALLOC: begin
            if (stack_depth_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               pop_req   = 1'b1;
               cnt_wa    = stk_rd_ff;
               new_count = COUNT_BITS'(1);
               cnt_we    = 1'b1;
               given     = stk_rd_ff;
               ref_out   = COUNT_BITS'(1);
            end
         end
         OP_WINDOW: begin
            status = ST_WINDOW;
         end
         default: ;
      endcase
   end

   // Sequence clearing pass, fetch and update
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      stack_depth_in = stack_depth_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == FRAME_BITS'(NUM_FRAMES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               stack_depth_in = stack_depth_ff + {{(DEPTH_BITS-1){1'b0}}, push_req}
                                - {{(DEPTH_BITS-1){1'b0}}, pop_req};
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status;
               rsp_data_in.given_frame = given;
               rsp_data_in.ref_count   = ref_out;
               rsp_data_in.free_frames = stack_depth_in;
               rsp_data_in.was_pushed  = push_req;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         stack_depth_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         stack_depth_ff <= stack_depth_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold the item and the response payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff <= head_op;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Count memory: clearing pass or update write, fetch read
   always_comb begin
      if (state_ff == S_CLEAR) begin
         cnt_wd = '0;
      end else begin
         cnt_wd = new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         count_mem_ff[clr_addr_ff] <= cnt_wd;
      end else if (exec_go && cnt_we) begin
         count_mem_ff[cnt_wa] <= cnt_wd;
      end
      if (q_pop) begin
         cnt_rd_ff <= count_mem_ff[head_op.frame];
      end
   end

   // Free stack: push at the top, fetch the top entry for alloc
   always_ff @(posedge clock) begin
      if (exec_go && push_req) begin
         stack_mem_ff[stack_depth_ff[FRAME_BITS-1:0]] <= op_ff.frame;
      end
      if (q_pop) begin
         stk_rd_ff <= stack_mem_ff[depth_less[FRAME_BITS-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PFA_ASSERT_SAME(a_depth_bound, 1'b1, stack_depth_ff <= DEPTH_FULL, "stack depth overflow")
   `PFA_ASSERT_SAME(a_no_rsp_clear, state_ff == S_CLEAR, !rsp_valid_ff, "response during clear")
   `PFA_ASSERT_NEXT(a_pop_exec, q_pop, state_ff == S_EXEC, "fetch not followed by update")
   `PFA_ASSERT_NEXT(a_push_depth, exec_go && push_req,
      stack_depth_ff == $past(stack_depth_ff) + 1'b1, "push did not grow stack")

endmodule

/* design/page_frame_allocator_refcount.sv */
// ---------------------------------------------------------------------------
// Page frame allocator with reference counts
// Free-frame stack plus per-frame saturating counts for copy-on-write.
// ---------------------------------------------------------------------------
//   channel   ports                          beat
//   request   req_valid / req_stall          req_data  (command, frame_index)
//   response  rsp_valid / rsp_stall          rsp_data  (status .. was_pushed)
//   config    csr_we, csr_index, csr_wdata   one register write
//
// Each item runs in two back-end steps: a read of the count memory and the
// stack top, then a write of the updated count and a push or pop of the stack.
// After reset a clearing pass zeroes all 16384 counts, one per cycle; req_stall
// stays high until the pass is done. Up to two classified items queue between
// front and back; a stalled response holds the back end in its update step.
// ---------------------------------------------------------------------------
module page_frame_allocator_refcount
   import pfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   back_status_type back_status;
   logic            q_full;
   logic            q_empty;
   logic            q_push;
   logic            q_pop;
   op_type          q_in_op;
   op_type          q_head_op;

   pfa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .back_status (back_status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_op        (q_in_op)
   );

   pfa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_in_op),
      .pop     (q_pop),
      .head_op (q_head_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   pfa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_op     (q_head_op),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
